@@ design/twk_pkg.sv @@
package twk_pkg;

	// table depths and accumulator width
	localparam int GLYPH_DEPTH = 256;
	localparam int KERN_DEPTH  = 1024;
	localparam int ACCUM_W     = 24;

	localparam int GAW    = $clog2(GLYPH_DEPTH);
	localparam int KAW    = $clog2(KERN_DEPTH);
	localparam int GCNT_W = $clog2(GLYPH_DEPTH + 1);
	localparam int KCNT_W = $clog2(KERN_DEPTH + 1);
	localparam int SRCH_W = GCNT_W + 2;
	localparam int PROD_W = ACCUM_W + 18;
	localparam int OUT_W  = 40;

	// ram word layouts
	localparam int GW_W = 16 + 11;
	localparam int KW_W = 16 + 16 + 8;
	localparam int FK_W = KAW + 1;

	localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
	localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

	// command codes
	localparam logic [1:0] CMD_GLYPH = 2'd0;
	localparam logic [1:0] CMD_KERN  = 2'd1;
	localparam logic [1:0] CMD_TEXT  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SPACING = 3'd0;
	localparam logic [2:0] REG_ESCAPES = 3'd1;
	localparam logic [2:0] REG_GCOUNT  = 3'd2;
	localparam logic [2:0] REG_KCOUNT  = 3'd3;
	localparam logic [2:0] REG_SCALE   = 3'd4;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_CHECK,
		SR_CMP
	} srch_state_t;

	typedef enum logic [4:0] {
		C_IDLE,
		C_GWR,
		C_KWR,
		C_KSRCH,
		C_KFK,
		C_TEXT,
		C_BSRCH,
		C_PSRCH,
		C_PFK,
		C_PRIME,
		C_PCMP,
		C_SCAN,
		C_SCMP,
		C_KADD,
		C_ADV,
		C_END,
		C_MUL,
		C_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic signed [7:0] spacing;
		logic              escapes_on;
		logic [8:0]        glyph_count;
		logic [10:0]       kern_count;
		logic [15:0]       scale_q8;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] key;
	} srch_req_t;

	typedef struct packed {
		logic               done;
		logic               found;
		logic [GAW-1:0]     index;
		logic signed [10:0] advance;
	} srch_rsp_t;

	typedef struct packed {
		logic               sat;
		logic [ACCUM_W-1:0] sum;
	} sat_res_t;

	// saturating add at accumulator width
	function automatic sat_res_t sat_add(logic [ACCUM_W-1:0] a, logic [ACCUM_W-1:0] d);
		logic [ACCUM_W:0] s;
		sat_res_t         r;
		s = {a[ACCUM_W-1], a} + {d[ACCUM_W-1], d};
		r.sat = s[ACCUM_W] ^ s[ACCUM_W-1];
		if (!r.sat) begin
			r.sum = s[ACCUM_W-1:0];
		end else if (s[ACCUM_W]) begin
			r.sum = {1'b1, {(ACCUM_W-1){1'b0}}};
		end else begin
			r.sum = {1'b0, {(ACCUM_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ design/text_width_kerning_engine.sv @@
// glyph write; kerning write plus one glyph search
// text byte: up to two glyph searches, up to 9 probes over 256 glyphs,
// plus a kerning scan over the kerning entries
// after its last byte the result is formed in C_MUL and C_OUT; one word at a time
// reset (arst_n low) clears control state and sets config to defaults (scale 256); the tables hold no reset values
module text_width_kerning_engine (
	input  logic               clk,
	input  logic               arst_n,
	// config port
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [9:0]         entry_index,
	input  logic [15:0]        glyph_code,
	input  logic signed [10:0] glyph_advance,
	input  logic [15:0]        kern_first,
	input  logic [15:0]        kern_second,
	input  logic signed [7:0]  kern_amount,
	input  logic [7:0]         text_byte,
	input  logic               last_byte,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [39:0] width_scaled,
	output logic               width_saturated
);

	twk_pkg::cfg_t      cfg_q;
	twk_pkg::srch_req_t sreq;
	twk_pkg::srch_rsp_t srsp;

	logic [twk_pkg::GCNT_W-1:0] gused;
	logic [twk_pkg::GAW-1:0]    g_raddr, g_waddr, f_waddr, f_raddr;
	logic [twk_pkg::GW_W-1:0]   g_rdata, g_wdata;
	logic [twk_pkg::FK_W-1:0]   f_wdata, f_rdata;
	logic [twk_pkg::KAW-1:0]    k_waddr, k_raddr;
	logic [twk_pkg::KW_W-1:0]   k_wdata, k_rdata;
	logic                       g_we, f_we, k_we;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spacing     <= '0;
			cfg_q.escapes_on  <= 1'b0;
			cfg_q.glyph_count <= '0;
			cfg_q.kern_count  <= '0;
			cfg_q.scale_q8    <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				twk_pkg::REG_SPACING: cfg_q.spacing     <= cfg_data[7:0];
				twk_pkg::REG_ESCAPES: cfg_q.escapes_on  <= cfg_data[0];
				twk_pkg::REG_GCOUNT:  cfg_q.glyph_count <= cfg_data[8:0];
				twk_pkg::REG_KCOUNT:  cfg_q.kern_count  <= cfg_data[10:0];
				twk_pkg::REG_SCALE:   cfg_q.scale_q8    <= cfg_data;
				default: ;
			endcase
		end
	end

	twk_ram #(.WIDTH(twk_pkg::GW_W), .DEPTH(twk_pkg::GLYPH_DEPTH)) u_glyph_ram (
		.clk(clk), .we(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
		.rd_addr(g_raddr), .rd_data(g_rdata)
	);

	twk_ram #(.WIDTH(twk_pkg::FK_W), .DEPTH(twk_pkg::GLYPH_DEPTH)) u_fk_ram (
		.clk(clk), .we(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
		.rd_addr(f_raddr), .rd_data(f_rdata)
	);

	twk_ram #(.WIDTH(twk_pkg::KW_W), .DEPTH(twk_pkg::KERN_DEPTH)) u_kern_ram (
		.clk(clk), .we(k_we), .wr_addr(k_waddr), .wr_data(k_wdata),
		.rd_addr(k_raddr), .rd_data(k_rdata)
	);

	twk_search u_search (
		.clk(clk), .arst_n(arst_n), .req(sreq), .used(gused),
		.rd_addr(g_raddr), .rd_data(g_rdata), .rsp(srsp)
	);

	twk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .entry_index(entry_index),
		.glyph_code(glyph_code), .glyph_advance(glyph_advance), .kern_first(kern_first),
		.kern_second(kern_second), .kern_amount(kern_amount), .text_byte(text_byte),
		.last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall), .width_scaled(width_scaled),
		.width_saturated(width_saturated),
		.sreq(sreq), .srsp(srsp), .gused(gused),
		.g_we(g_we), .g_waddr(g_waddr), .g_wdata(g_wdata),
		.f_we(f_we), .f_waddr(f_waddr), .f_wdata(f_wdata), .f_raddr(f_raddr),
		.f_rdata(f_rdata),
		.k_we(k_we), .k_waddr(k_waddr), .k_wdata(k_wdata), .k_raddr(k_raddr),
		.k_rdata(k_rdata)
	);

endmodule

@@ design/twk_ram.sv @@
module twk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ design/twk_search.sv @@
module twk_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  twk_pkg::srch_req_t            req,
	input  logic [twk_pkg::GCNT_W-1:0]    used,
	output logic [twk_pkg::GAW-1:0]       rd_addr,
	input  logic [twk_pkg::GW_W-1:0]      rd_data,
	output twk_pkg::srch_rsp_t            rsp
);

	twk_pkg::srch_state_t st_q, st_d;

	logic signed [twk_pkg::SRCH_W-1:0] lo_q, hi_q, mid_q, mid;
	logic [15:0]                       key_q;
	logic [15:0]                       code;
	logic                              empty;
	logic                              hit;
	logic                              done_q, found_q;
	logic [twk_pkg::GAW-1:0]           idx_q;
	logic signed [10:0]                adv_q;

	// midpoint and compare
	always_comb begin
		mid   = (lo_q + hi_q) >>> 1;
		empty = lo_q > hi_q;
		code  = rd_data[twk_pkg::GW_W-1:11];
		hit   = code == key_q;
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			twk_pkg::SR_IDLE:  if (req.start) st_d = twk_pkg::SR_CHECK;
			twk_pkg::SR_CHECK: st_d = empty ? twk_pkg::SR_IDLE : twk_pkg::SR_CMP;
			twk_pkg::SR_CMP:   st_d = hit ? twk_pkg::SR_IDLE : twk_pkg::SR_CHECK;
			default:           st_d = twk_pkg::SR_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_addr     = mid[twk_pkg::GAW-1:0];
		rsp.done    = done_q;
		rsp.found   = found_q;
		rsp.index   = idx_q;
		rsp.advance = adv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= twk_pkg::SR_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			unique case (st_q)
				twk_pkg::SR_IDLE: begin
					if (req.start) begin
						lo_q  <= '0;
						hi_q  <= twk_pkg::SRCH_W'(used) - twk_pkg::SRCH_W'(1);
						key_q <= req.key;
					end
				end
				twk_pkg::SR_CHECK: begin
					mid_q <= mid;
					if (empty) begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
					end
				end
				twk_pkg::SR_CMP: begin
					if (hit) begin
						done_q  <= 1'b1;
						found_q <= 1'b1;
						idx_q   <= mid_q[twk_pkg::GAW-1:0];
						adv_q   <= rd_data[10:0];
					end else if (code > key_q) begin
						hi_q <= mid_q - twk_pkg::SRCH_W'(1);
					end else begin
						lo_q <= mid_q + twk_pkg::SRCH_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ design/twk_ctrl.sv @@
module twk_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  twk_pkg::cfg_t                    cfg,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       cmd,
	input  logic [9:0]                       entry_index,
	input  logic [15:0]                      glyph_code,
	input  logic signed [10:0]               glyph_advance,
	input  logic [15:0]                      kern_first,
	input  logic [15:0]                      kern_second,
	input  logic signed [7:0]                kern_amount,
	input  logic [7:0]                       text_byte,
	input  logic                             last_byte,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [39:0]               width_scaled,
	output logic                             width_saturated,
	// search unit
	output twk_pkg::srch_req_t               sreq,
	input  twk_pkg::srch_rsp_t               srsp,
	output logic [twk_pkg::GCNT_W-1:0]       gused,
	// glyph ram write
	output logic                             g_we,
	output logic [twk_pkg::GAW-1:0]          g_waddr,
	output logic [twk_pkg::GW_W-1:0]         g_wdata,
	// first kerning ram
	output logic                             f_we,
	output logic [twk_pkg::GAW-1:0]          f_waddr,
	output logic [twk_pkg::FK_W-1:0]         f_wdata,
	output logic [twk_pkg::GAW-1:0]          f_raddr,
	input  logic [twk_pkg::FK_W-1:0]         f_rdata,
	// kerning ram
	output logic                             k_we,
	output logic [twk_pkg::KAW-1:0]          k_waddr,
	output logic [twk_pkg::KW_W-1:0]         k_wdata,
	output logic [twk_pkg::KAW-1:0]          k_raddr,
	input  logic [twk_pkg::KW_W-1:0]         k_rdata
);

	localparam int AW = twk_pkg::ACCUM_W;

	twk_pkg::ctrl_state_t st_q, st_d;

	// latched word
	logic [9:0]         slot_q;
	logic [15:0]        gcode_q;
	logic signed [10:0] gadv_q;
	logic [15:0]        kfirst_q, ksecond_q;
	logic signed [7:0]  kamt_q;
	logic [7:0]         byte_q;
	logic               last_q;

	// string state
	logic [AW-1:0]      accum_q;
	logic [7:0]         prev_code_q;
	logic               prev_valid_q;
	logic               esc_q;
	logic               stopped_q;
	logic               sat_q;

	// per byte work
	logic signed [10:0]              adv_q;
	logic signed [7:0]               kern_q;
	logic [twk_pkg::KCNT_W-1:0]      a_q;
	logic                            flag_q;
	logic [twk_pkg::GAW-1:0]         gidx_q;
	logic signed [twk_pkg::PROD_W-1:0] prod_s1;

	// output register
	logic               out_valid_q;
	logic signed [39:0] width_q;
	logic               wsat_q;

	// decode
	logic                       in_acc;
	logic                       slot_g_ok, slot_k_ok;
	logic [twk_pkg::KCNT_W-1:0] kused;
	logic [7:0]                 b_eff;
	logic                       esc_start;
	logic                       fk_valid;
	logic [twk_pkg::KAW-1:0]    fk_idx;
	logic [15:0]                k_first, k_second;
	logic signed [7:0]          k_amt;
	logic                       first_hit, second_hit;
	logic [twk_pkg::KCNT_W-1:0] a_dec;
	logic                       out_free;
	logic signed [11:0]         adv_sp;
	logic signed [AW:0]         diff;
	logic signed [63:0]         p64;
	twk_pkg::sat_res_t          add_k, add_a;

	always_comb begin
		in_acc    = in_valid && !in_stall;
		slot_g_ok = 32'(slot_q) < twk_pkg::GLYPH_DEPTH;
		slot_k_ok = 32'(slot_q) < twk_pkg::KERN_DEPTH;
		gused = (32'(cfg.glyph_count) > twk_pkg::GLYPH_DEPTH) ?
			twk_pkg::GCNT_W'(twk_pkg::GLYPH_DEPTH) : twk_pkg::GCNT_W'(cfg.glyph_count);
		kused = (32'(cfg.kern_count) > twk_pkg::KERN_DEPTH) ?
			twk_pkg::KCNT_W'(twk_pkg::KERN_DEPTH) : twk_pkg::KCNT_W'(cfg.kern_count);
		// escape translation
		b_eff = byte_q;
		if (cfg.escapes_on && esc_q) begin
			case (byte_q)
				twk_pkg::CH_N: b_eff = twk_pkg::CH_LF;
				twk_pkg::CH_R: b_eff = twk_pkg::CH_CR;
				twk_pkg::CH_T: b_eff = twk_pkg::CH_TAB;
				default:       b_eff = byte_q;
			endcase
		end
		esc_start  = cfg.escapes_on && !esc_q && byte_q == twk_pkg::CH_BSLASH;
		fk_valid   = f_rdata[twk_pkg::FK_W-1];
		fk_idx     = f_rdata[twk_pkg::KAW-1:0];
		k_first    = k_rdata[39:24];
		k_second   = k_rdata[23:8];
		k_amt      = k_rdata[7:0];
		first_hit  = k_first == {8'h00, prev_code_q};
		second_hit = k_second == {8'h00, byte_q};
		a_dec      = a_q - twk_pkg::KCNT_W'(1);
		out_free   = !out_valid_q || !out_stall;
		adv_sp     = 12'(adv_q) + 12'(cfg.spacing);
		add_k      = twk_pkg::sat_add(accum_q, AW'(kern_q));
		add_a      = twk_pkg::sat_add(accum_q, AW'(adv_sp));
		diff       = (AW+1)'($signed(accum_q)) - (AW+1)'(cfg.spacing);
		p64        = 64'(prod_s1);
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			twk_pkg::C_IDLE: begin
				if (in_acc) begin
					case (cmd)
						twk_pkg::CMD_GLYPH: st_d = twk_pkg::C_GWR;
						twk_pkg::CMD_KERN:  st_d = twk_pkg::C_KWR;
						twk_pkg::CMD_TEXT:  st_d = twk_pkg::C_TEXT;
						default:            st_d = twk_pkg::C_IDLE;
					endcase
				end
			end
			twk_pkg::C_GWR: st_d = twk_pkg::C_IDLE;
			twk_pkg::C_KWR: st_d = slot_k_ok ? twk_pkg::C_KSRCH : twk_pkg::C_IDLE;
			twk_pkg::C_KSRCH: begin
				if (srsp.done) st_d = srsp.found ? twk_pkg::C_KFK : twk_pkg::C_IDLE;
			end
			twk_pkg::C_KFK: st_d = twk_pkg::C_IDLE;
			twk_pkg::C_TEXT: begin
				if (stopped_q) st_d = twk_pkg::C_IDLE;
				else if (byte_q == 8'h00) st_d = twk_pkg::C_MUL;
				else if (esc_start) st_d = last_q ? twk_pkg::C_MUL : twk_pkg::C_IDLE;
				else st_d = twk_pkg::C_BSRCH;
			end
			twk_pkg::C_BSRCH: begin
				if (srsp.done) begin
					if (!srsp.found) st_d = twk_pkg::C_END;
					else if (prev_valid_q) st_d = twk_pkg::C_PSRCH;
					else st_d = twk_pkg::C_ADV;
				end
			end
			twk_pkg::C_PSRCH: begin
				if (srsp.done) st_d = srsp.found ? twk_pkg::C_PFK : twk_pkg::C_SCAN;
			end
			twk_pkg::C_PFK: begin
				if (!fk_valid) st_d = twk_pkg::C_ADV;
				else if (fk_idx == '0) st_d = twk_pkg::C_SCAN;
				else st_d = twk_pkg::C_PRIME;
			end
			twk_pkg::C_PRIME: st_d = twk_pkg::C_PCMP;
			twk_pkg::C_PCMP:  st_d = twk_pkg::C_SCAN;
			twk_pkg::C_SCAN:  st_d = (a_q < kused) ? twk_pkg::C_SCMP : twk_pkg::C_ADV;
			twk_pkg::C_SCMP: begin
				if (first_hit) st_d = second_hit ? twk_pkg::C_KADD : twk_pkg::C_SCAN;
				else st_d = flag_q ? twk_pkg::C_ADV : twk_pkg::C_SCAN;
			end
			twk_pkg::C_KADD: st_d = twk_pkg::C_ADV;
			twk_pkg::C_ADV:  st_d = twk_pkg::C_END;
			twk_pkg::C_END:  st_d = last_q ? twk_pkg::C_MUL : twk_pkg::C_IDLE;
			twk_pkg::C_MUL:  st_d = twk_pkg::C_OUT;
			twk_pkg::C_OUT:  st_d = out_free ? twk_pkg::C_IDLE : twk_pkg::C_OUT;
			default:         st_d = twk_pkg::C_IDLE;
		endcase
	end

	// outputs: handshake, search requests, ram ports
	always_comb begin
		in_stall        = st_q != twk_pkg::C_IDLE;
		out_valid       = out_valid_q;
		width_scaled    = width_q;
		width_saturated = wsat_q;
		sreq.start = 1'b0;
		sreq.key   = kfirst_q;
		g_we    = st_q == twk_pkg::C_GWR && slot_g_ok;
		g_waddr = slot_q[twk_pkg::GAW-1:0];
		g_wdata = {gcode_q, gadv_q};
		f_we    = 1'b0;
		f_waddr = gidx_q;
		f_wdata = {1'b1, twk_pkg::KAW'(slot_q)};
		f_raddr = srsp.index;
		k_we    = st_q == twk_pkg::C_KWR && slot_k_ok;
		k_waddr = twk_pkg::KAW'(slot_q);
		k_wdata = {kfirst_q, ksecond_q, kamt_q};
		k_raddr = a_q[twk_pkg::KAW-1:0];
		unique case (st_q)
			twk_pkg::C_GWR: begin
				f_we    = slot_g_ok;
				f_waddr = slot_q[twk_pkg::GAW-1:0];
				f_wdata = '0;
			end
			twk_pkg::C_KWR: begin
				sreq.start = slot_k_ok;
			end
			twk_pkg::C_KFK: begin
				f_we = !fk_valid;
			end
			twk_pkg::C_TEXT: begin
				sreq.start = !stopped_q && byte_q != 8'h00 && !esc_start;
				sreq.key   = {8'h00, b_eff};
			end
			twk_pkg::C_BSRCH: begin
				sreq.start = srsp.done && srsp.found && prev_valid_q;
				sreq.key   = {8'h00, prev_code_q};
			end
			twk_pkg::C_PRIME: begin
				k_raddr = a_dec[twk_pkg::KAW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= twk_pkg::C_IDLE;
			accum_q      <= '0;
			prev_valid_q <= 1'b0;
			prev_code_q  <= '0;
			esc_q        <= 1'b0;
			stopped_q    <= 1'b0;
			sat_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			// result word valid: set on a new word, cleared once taken
			if (st_q == twk_pkg::C_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				twk_pkg::C_IDLE: begin
					// latch the incoming word
					if (in_acc) begin
						slot_q    <= entry_index;
						gcode_q   <= glyph_code;
						gadv_q    <= glyph_advance;
						kfirst_q  <= kern_first;
						ksecond_q <= kern_second;
						kamt_q    <= kern_amount;
						byte_q    <= text_byte;
						last_q    <= last_byte;
					end
				end
				twk_pkg::C_KSRCH: begin
					if (srsp.done) gidx_q <= srsp.index;
				end
				twk_pkg::C_TEXT: begin
					if (stopped_q) begin
						if (last_q) stopped_q <= 1'b0;
					end else if (byte_q == 8'h00) begin
						stopped_q <= !last_q;
					end else if (esc_start) begin
						esc_q <= 1'b1;
					end else begin
						if (cfg.escapes_on && esc_q) esc_q <= 1'b0;
						byte_q <= b_eff;
					end
				end
				twk_pkg::C_BSRCH: begin
					if (srsp.done) begin
						adv_q  <= srsp.advance;
						kern_q <= '0;
						if (!srsp.found) begin
							prev_valid_q <= 1'b0;
							prev_code_q  <= '0;
						end
					end
				end
				twk_pkg::C_PSRCH: begin
					// previous code gone: scan from slot zero
					a_q    <= '0;
					flag_q <= 1'b0;
				end
				twk_pkg::C_PFK: begin
					a_q    <= twk_pkg::KCNT_W'(fk_idx);
					flag_q <= 1'b0;
				end
				twk_pkg::C_PCMP: begin
					flag_q <= first_hit;
				end
				twk_pkg::C_SCMP: begin
					if (first_hit && second_hit) begin
						kern_q <= k_amt;
					end
					flag_q <= first_hit;
					a_q    <= a_q + twk_pkg::KCNT_W'(1);
				end
				twk_pkg::C_KADD: begin
					accum_q <= add_k.sum;
					if (add_k.sat) sat_q <= 1'b1;
				end
				twk_pkg::C_ADV: begin
					accum_q      <= add_a.sum;
					if (add_a.sat) sat_q <= 1'b1;
					prev_code_q  <= byte_q;
					prev_valid_q <= 1'b1;
				end
				twk_pkg::C_MUL: begin
					prod_s1 <= twk_pkg::PROD_W'(diff) *
						twk_pkg::PROD_W'($signed({1'b0, cfg.scale_q8}));
				end
				twk_pkg::C_OUT: begin
					// clamp, present the result word, clear the string state
					if (out_free) begin
						if (p64 > twk_pkg::OUT_MAX) begin
							width_q <= twk_pkg::OUT_MAX[39:0];
							wsat_q  <= 1'b1;
						end else if (p64 < twk_pkg::OUT_MIN) begin
							width_q <= twk_pkg::OUT_MIN[39:0];
							wsat_q  <= 1'b1;
						end else begin
							width_q <= p64[39:0];
							wsat_q  <= sat_q;
						end
						accum_q      <= '0;
						prev_valid_q <= 1'b0;
						prev_code_q  <= '0;
						esc_q        <= 1'b0;
						sat_q        <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ design/twk_checker.sv @@
module twk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_stall,
	input logic [39:0] width_scaled,
	input logic        width_saturated
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(width_scaled) && $stable(width_saturated))
		else $error("result word changed while stalled");

	// any real command leaves the block busy right after it is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != twk_pkg::CMD_NONE |=> in_stall)
		else $error("block ready right after accepting a command");

	// a new result only comes out of a busy block
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

bind text_width_kerning_engine twk_checker u_twk_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
	.out_valid(out_valid), .out_stall(out_stall), .width_scaled(width_scaled),
	.width_saturated(width_saturated)
);
